/* hdl/dtod_pkg.sv */
`default_nettype none
package dtod_pkg;

  // defaults for the top level parameters
  localparam int unsigned WINDOW_DEF    = 20;
  localparam int unsigned COUNT_CAP_DEF = 60;

  // detector constants
  localparam int unsigned MIN_DELTAS       = 2;
  localparam int unsigned OVERUSE_TIME_US  = 10000;
  localparam int unsigned MAX_ADAPT_OFFSET = 240;
  localparam int unsigned MAX_ADAPT_MS     = 100;
  localparam int unsigned TH_MIN           = 96;
  localparam int unsigned TH_MAX           = 9600;
  localparam int unsigned COEF_ONE         = 1024;
  localparam int unsigned SLOPE_SCALE      = 1000;

  // fit datapath widths, sized for the largest window
  localparam int unsigned WIDE = 128;
  localparam int unsigned SXW  = 40;
  localparam int unsigned SYW  = 56;

  // saturation bound of the accumulated delay
  localparam logic signed [49:0] Y_MAX = 50'sh0_7FFF_FFFF_FFFF;

  // register reset values
  localparam logic [10:0] SMOOTHING_COEF_RST  = 11'd922;
  localparam logic [7:0]  TREND_GAIN_RST      = 8'd64;
  localparam logic [15:0] ADAPT_RATE_UP_RST   = 16'd570;
  localparam logic [15:0] ADAPT_RATE_DOWN_RST = 16'd2556;
  localparam logic [13:0] START_THRESHOLD_RST = 14'd200;

  // register indexes
  localparam logic [2:0] REG_SMOOTHING_COEF  = 3'd0;
  localparam logic [2:0] REG_TREND_GAIN      = 3'd1;
  localparam logic [2:0] REG_ADAPT_RATE_UP   = 3'd2;
  localparam logic [2:0] REG_ADAPT_RATE_DOWN = 3'd3;
  localparam logic [2:0] REG_START_THRESHOLD = 3'd4;

  typedef enum logic [1:0] {
    USAGE_NORMAL = 2'd0,
    USAGE_OVER   = 2'd1,
    USAGE_UNDER  = 2'd2
  } usage_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ACC, ST_SMOOTH, ST_WRITE, ST_RD, ST_XX, ST_XYLO, ST_XYHI,
    ST_DEN_INIT, ST_DEN, ST_NUM_INIT, ST_NUM, ST_DIV_INIT, ST_DIV,
    ST_SCALE1, ST_SCALE2, ST_DETECT, ST_ADAPT1, ST_ADAPT2, ST_OUT
  } st_e;

  typedef struct packed {
    logic [10:0] smoothing_coef;
    logic [7:0]  trend_gain;
    logic [15:0] adapt_rate_up;
    logic [15:0] adapt_rate_down;
    logic [13:0] start_threshold;
    logic        th_load;
  } cfg_t;

endpackage
`default_nettype wire

/* hdl/dtod_if.sv */
`default_nettype none
interface dtod_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] recv_delta_us;
  logic signed [23:0] send_delta_us;
  logic [47:0]        arrival_ms;
  logic               delta_valid;

  modport source(output valid, recv_delta_us, send_delta_us, arrival_ms, delta_valid,
                 input ready);
  modport sink(input valid, recv_delta_us, send_delta_us, arrival_ms, delta_valid,
               output ready);
endinterface

interface dtod_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         usage;
  logic signed [31:0] scaled_trend;
  logic [13:0]        cur_threshold;

  modport source(output valid, usage, scaled_trend, cur_threshold, input ready);
  modport sink(input valid, usage, scaled_trend, cur_threshold, output ready);
endinterface
`default_nettype wire

/* hdl/dtod_window_mem.sv */
`default_nettype none
module dtod_window_mem #(
  parameter int unsigned DEPTH = 20,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 80
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire

/* hdl/dtod_cfg.sv */
`default_nettype none
module dtod_cfg
  import dtod_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [10:0] coef_q;
  logic [7:0]  gain_q;
  logic [15:0] up_q, down_q;
  logic [13:0] start_q;
  logic        load_q;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= SMOOTHING_COEF_RST;
      gain_q  <= TREND_GAIN_RST;
      up_q    <= ADAPT_RATE_UP_RST;
      down_q  <= ADAPT_RATE_DOWN_RST;
      start_q <= START_THRESHOLD_RST;
      load_q  <= 1'b0;
    end else begin
      load_q <= 1'b0;
      if (wr) begin
        case (idx)
          REG_SMOOTHING_COEF:  coef_q <= pwdata[10:0];
          REG_TREND_GAIN:      gain_q <= pwdata[7:0];
          REG_ADAPT_RATE_UP:   up_q   <= pwdata[15:0];
          REG_ADAPT_RATE_DOWN: down_q <= pwdata[15:0];
          REG_START_THRESHOLD: begin
            start_q <= pwdata[13:0];
            load_q  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_SMOOTHING_COEF:  prdata = {21'd0, coef_q};
      REG_TREND_GAIN:      prdata = {24'd0, gain_q};
      REG_ADAPT_RATE_UP:   prdata = {16'd0, up_q};
      REG_ADAPT_RATE_DOWN: prdata = {16'd0, down_q};
      REG_START_THRESHOLD: prdata = {18'd0, start_q};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{smoothing_coef: coef_q, trend_gain: gain_q, adapt_rate_up: up_q,
                   adapt_rate_down: down_q, start_threshold: start_q, th_load: load_q};

endmodule
`default_nettype wire

/* hdl/dtod_core.sv */
`default_nettype none
module dtod_core
  import dtod_pkg::*;
#(
  parameter int unsigned WINDOW    = WINDOW_DEF,
  parameter int unsigned COUNT_CAP = COUNT_CAP_DEF,
  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int unsigned FW = $clog2(WINDOW + 1)
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  cfg_t         cfg_i,
  dtod_in_if.sink      in_i,
  dtod_out_if.source   out_o,
  output logic          mem_we_o,
  output logic [IW-1:0] mem_waddr_o,
  output logic [79:0]   mem_wdata_o,
  output logic [IW-1:0] mem_raddr_o,
  input  wire logic [79:0] mem_rdata_i
);

  localparam int unsigned CW = $clog2(COUNT_CAP + 1);
  localparam int unsigned GW = CW + 8;
  localparam int unsigned PW = GW + 1 + 32;

  st_e state_q, state_d;

  // input item
  logic signed [23:0] recv_q, send_q;
  logic [47:0]        now_q;

  // filter and window state
  logic [47:0]        origin_q, origin_d;
  logic               oseen_q, oseen_d;
  logic [CW-1:0]      count_q, count_d;
  logic signed [47:0] accum_q, accum_d, smooth_q, smooth_d;
  logic [31:0]        rel_q, rel_d;
  logic [IW-1:0]      head_q, head_d, idx_q, idx_d;
  logic [FW-1:0]      fill_q, fill_d;

  // detector state
  logic signed [31:0] last_trend_q, last_trend_d, trend_q, trend_d;
  logic signed [31:0] ou_time_q, ou_time_d, scaled_q, scaled_d;
  logic               armed_q, armed_d;
  logic [7:0]         hits_q, hits_d;
  usage_e             usage_q, usage_d;
  logic [13:0]        th_q, th_d;
  logic [47:0]        last_ad_q, last_ad_d;
  logic               adseen_q, adseen_d;

  // fit accumulators and shared serial unit
  logic [SXW-1:0]        sx_q, sx_d, mplier_q, mplier_d;
  logic signed [SYW-1:0] sy_q, sy_d;
  logic [WIDE-1:0]       sxx_q, sxx_d, sxy_q, sxy_d, acc_q, acc_d, mcand_q, mcand_d;
  logic [WIDE-1:0]       den_q, den_d, rem_q, rem_d, dd_q, dd_d;
  logic                  neg_q, neg_d;
  logic [30:0]           quo_q, quo_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [31:0]           x_q, x_d;
  logic [47:0]           ymag_q, ymag_d;
  logic                  yneg_q, yneg_d;
  logic [55:0]           xylo_q, xylo_d;

  // scaling and adaptation
  logic [GW-1:0]         cg_q, cg_d;
  logic [15:0]           k_q, k_d;
  logic signed [33:0]    diff_q, diff_d;
  logic [6:0]            dt_q, dt_d;
  logic signed [50:0]    kd_q, kd_d;

  // output register
  logic               ovalid_q, ovalid_d;
  logic [1:0]         ousage_q, ousage_d;
  logic signed [31:0] oscaled_q, oscaled_d;
  logic [13:0]        oth_q, oth_d;

  // shared 128 bit add/subtract
  logic [WIDE-1:0] alu_a, alu_b, alu_y;
  logic            alu_sub;
  assign alu_y = alu_a + (alu_b ^ {WIDE{alu_sub}}) + {{(WIDE-1){1'b0}}, alu_sub};

  // scratch values
  logic signed [49:0] asum;
  logic [47:0]        org;
  logic [48:0]        reld;
  logic [10:0]        coef;
  logic signed [60:0] ssum;
  logic [31:0]        xv;
  logic signed [47:0] yv;
  logic [79:0]        xyt;
  logic [WIDE-1:0]    mag;
  logic [30:0]        qf;
  logic signed [PW-1:0] sprod;
  logic signed [32:0] sc33, th33;
  logic signed [33:0] ou_sum;
  logic signed [24:0] half;
  logic signed [31:0] nt;
  logic [7:0]         nh;
  logic [31:0]        smag;
  logic [47:0]        la;
  logic [48:0]        dtw;
  logic signed [58:0] adj, rnd;
  logic signed [58:0] thn;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = ovalid_q;
  assign out_o.usage       = ousage_q;
  assign out_o.scaled_trend = oscaled_q;
  assign out_o.cur_threshold = oth_q;

  assign mem_waddr_o = head_q;
  assign mem_wdata_o = {rel_q, smooth_q};
  assign mem_raddr_o = idx_q;
  assign mem_we_o    = (state_q == ST_WRITE);

  // state register and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      origin_q     <= '0;
      oseen_q      <= 1'b0;
      count_q      <= '0;
      accum_q      <= '0;
      smooth_q     <= '0;
      head_q       <= '0;
      fill_q       <= '0;
      last_trend_q <= '0;
      ou_time_q    <= '0;
      armed_q      <= 1'b0;
      hits_q       <= '0;
      usage_q      <= USAGE_NORMAL;
      th_q         <= START_THRESHOLD_RST;
      last_ad_q    <= '0;
      adseen_q     <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      origin_q     <= origin_d;
      oseen_q      <= oseen_d;
      count_q      <= count_d;
      accum_q      <= accum_d;
      smooth_q     <= smooth_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      last_trend_q <= last_trend_d;
      ou_time_q    <= ou_time_d;
      armed_q      <= armed_d;
      hits_q       <= hits_d;
      usage_q      <= usage_d;
      th_q         <= th_d;
      last_ad_q    <= last_ad_d;
      adseen_q     <= adseen_d;
      ovalid_q     <= ovalid_d;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      recv_q <= in_i.recv_delta_us;
      send_q <= in_i.send_delta_us;
      now_q  <= in_i.arrival_ms;
    end
    rel_q <= rel_d;   idx_q <= idx_d;     trend_q <= trend_d;  scaled_q <= scaled_d;
    sx_q <= sx_d;     sy_q <= sy_d;       sxx_q <= sxx_d;      sxy_q <= sxy_d;
    acc_q <= acc_d;   mcand_q <= mcand_d; mplier_q <= mplier_d;
    den_q <= den_d;   rem_q <= rem_d;     dd_q <= dd_d;        neg_q <= neg_d;
    quo_q <= quo_d;   cnt_q <= cnt_d;     x_q <= x_d;          ymag_q <= ymag_d;
    yneg_q <= yneg_d; xylo_q <= xylo_d;   cg_q <= cg_d;        k_q <= k_d;
    diff_q <= diff_d; dt_q <= dt_d;       kd_q <= kd_d;
    ousage_q <= ousage_d; oscaled_q <= oscaled_d; oth_q <= oth_d;
  end

  // sequencer: next state and datapath
  always_comb begin
    state_d = state_q;
    origin_d = origin_q; oseen_d = oseen_q; count_d = count_q;
    accum_d = accum_q; smooth_d = smooth_q; rel_d = rel_q;
    head_d = head_q; fill_d = fill_q; idx_d = idx_q;
    last_trend_d = last_trend_q; trend_d = trend_q; scaled_d = scaled_q;
    ou_time_d = ou_time_q; armed_d = armed_q; hits_d = hits_q; usage_d = usage_q;
    th_d = th_q; last_ad_d = last_ad_q; adseen_d = adseen_q;
    sx_d = sx_q; sy_d = sy_q; sxx_d = sxx_q; sxy_d = sxy_q;
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    den_d = den_q; rem_d = rem_q; dd_d = dd_q; neg_d = neg_q;
    quo_d = quo_q; cnt_d = cnt_q; x_d = x_q; ymag_d = ymag_q; yneg_d = yneg_q;
    xylo_d = xylo_q; cg_d = cg_q; k_d = k_q; diff_d = diff_q; dt_d = dt_q; kd_d = kd_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ousage_d = ousage_q; oscaled_d = oscaled_q; oth_d = oth_q;
    alu_a = acc_q; alu_b = mcand_q; alu_sub = 1'b1;

    asum = 50'(accum_q) + 50'(recv_q) - 50'(send_q);
    org  = oseen_q ? origin_q : now_q;
    reld = {1'b0, now_q} - {1'b0, org};
    coef = (cfg_i.smoothing_coef > 11'(COEF_ONE)) ? 11'(COEF_ONE) : cfg_i.smoothing_coef;
    ssum = 61'($signed({1'b0, coef}) * smooth_q)
         + 61'($signed({1'b0, 11'(11'(COEF_ONE) - coef)}) * accum_q) + 61'sd512;
    xv   = mem_rdata_i[79:48];
    yv   = $signed(mem_rdata_i[47:0]);
    xyt  = 80'(xylo_q) + {56'(x_q * ymag_q[47:24]), 24'd0};
    mag  = acc_q[WIDE-1] ? (~acc_q + 1'b1) : acc_q;
    qf   = {quo_q[29:0], 1'b0};
    sprod = $signed({1'b0, cg_q}) * trend_q;
    sc33 = 33'(scaled_q);
    th33 = $signed({19'd0, th_q});
    ou_sum = 34'(ou_time_q) + 34'(send_q);
    half = (25'(send_q) + {24'd0, send_q[23]}) >>> 1;
    nt   = 32'(half);
    nh   = (hits_q == 8'hFF) ? hits_q : hits_q + 8'd1;
    smag = scaled_q[31] ? 32'(-scaled_q) : 32'(scaled_q);
    la   = adseen_q ? last_ad_q : now_q;
    dtw  = {1'b0, now_q} - {1'b0, la};
    adj  = 59'(kd_q * $signed({1'b0, dt_q}));
    rnd  = (adj + 59'sd32768) >>> 16;
    thn  = 59'($signed({1'b0, th_q})) + rnd;

    // a start threshold write reloads the threshold
    if (cfg_i.th_load) begin
      if (cfg_i.start_threshold < 14'(TH_MIN)) th_d = 14'(TH_MIN);
      else if (cfg_i.start_threshold > 14'(TH_MAX)) th_d = 14'(TH_MAX);
      else th_d = cfg_i.start_threshold;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          scaled_d = '0;
          state_d  = in_i.delta_valid ? ST_ACC : ST_OUT;
        end
      end
      // origin, sample count, accumulated delay, relative arrival
      ST_ACC: begin
        origin_d = org;
        oseen_d  = 1'b1;
        if (count_q < CW'(COUNT_CAP)) count_d = count_q + 1'b1;
        if (asum > Y_MAX) accum_d = 48'(Y_MAX);
        else if (asum < -Y_MAX) accum_d = 48'(-Y_MAX);
        else accum_d = 48'(asum);
        if (now_q < org) rel_d = '0;
        else if (reld[47:32] != '0) rel_d = '1;
        else rel_d = reld[31:0];
        state_d = ST_SMOOTH;
      end
      // exponential smoothing, rounded division by 1024
      ST_SMOOTH: begin
        smooth_d = ssum[57:10];
        state_d  = ST_WRITE;
      end
      // window write, start the fit once full
      ST_WRITE: begin
        head_d = (head_q == IW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
        if (fill_q < FW'(WINDOW)) fill_d = fill_q + 1'b1;
        if (fill_q >= FW'(WINDOW - 1)) begin
          idx_d = '0; sx_d = '0; sy_d = '0; sxx_d = '0; sxy_d = '0;
          state_d = ST_RD;
        end else begin
          trend_d = last_trend_q;
          state_d = ST_SCALE1;
        end
      end
      ST_RD: state_d = ST_XX;
      // running sums over the window
      ST_XX: begin
        sx_d   = sx_q + SXW'(xv);
        sy_d   = sy_q + SYW'(yv);
        sxx_d  = sxx_q + WIDE'(xv * xv);
        x_d    = xv;
        yneg_d = yv[47];
        ymag_d = yv[47] ? 48'(-yv) : 48'(yv);
        state_d = ST_XYLO;
      end
      ST_XYLO: begin
        xylo_d  = 56'(x_q * ymag_q[23:0]);
        state_d = ST_XYHI;
      end
      ST_XYHI: begin
        sxy_d = yneg_q ? sxy_q - WIDE'(xyt) : sxy_q + WIDE'(xyt);
        if (idx_q == IW'(WINDOW - 1)) begin
          state_d = ST_DEN_INIT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_RD;
        end
      end
      // den = n*sxx - sx*sx, product by shift and subtract
      ST_DEN_INIT: begin
        acc_d    = WIDE'(sxx_q * WIDE'(WINDOW));
        mcand_d  = WIDE'(sx_q);
        mplier_d = sx_q;
        state_d  = ST_DEN;
      end
      ST_DEN, ST_NUM: begin
        if (mplier_q == '0) begin
          if (state_q == ST_DEN) begin
            den_d   = acc_q;
            state_d = ST_NUM_INIT;
          end else begin
            neg_d   = acc_q[WIDE-1];
            rem_d   = mag << 16;
            dd_d    = WIDE'(den_q * WIDE'(SLOPE_SCALE));
            state_d = ST_DIV_INIT;
          end
        end else begin
          if (mplier_q[0]) acc_d = alu_y;
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end
      // num = n*sxy - sx*sy
      ST_NUM_INIT: begin
        if (den_q == '0) begin
          trend_d = last_trend_q;
          state_d = ST_SCALE1;
        end else begin
          acc_d    = WIDE'($signed(sxy_q) * $signed(WIDE'(WINDOW)));
          mcand_d  = WIDE'(sy_q);
          mplier_d = sx_q;
          state_d  = ST_NUM;
        end
      end
      // saturation check against d << 31
      ST_DIV_INIT: begin
        alu_a = rem_q;
        alu_b = dd_q << 31;
        if (!alu_y[WIDE-1]) begin
          trend_d = neg_q ? -32'sh7FFF_FFFF : 32'sh7FFF_FFFF;
          state_d = ST_SCALE1;
        end else begin
          dd_d    = dd_q << 30;
          cnt_d   = 5'd30;
          quo_d   = '0;
          state_d = ST_DIV;
        end
      end
      // restoring division, one quotient bit per cycle
      ST_DIV: begin
        alu_a = rem_q;
        alu_b = dd_q;
        if (!alu_y[WIDE-1]) rem_d = alu_y;
        quo_d = {quo_q[29:0], !alu_y[WIDE-1]};
        dd_d  = dd_q >> 1;
        if (cnt_q == '0) begin
          trend_d = neg_q ? -$signed({1'b0, qf | {30'd0, !alu_y[WIDE-1]}})
                          : $signed({1'b0, qf | {30'd0, !alu_y[WIDE-1]}});
          state_d = ST_SCALE1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_SCALE1: begin
        cg_d    = GW'(count_q * cfg_i.trend_gain);
        state_d = ST_SCALE2;
      end
      ST_SCALE2: begin
        scaled_d = 32'(sprod >>> 16);
        if (count_q < CW'(MIN_DELTAS)) begin
          usage_d = USAGE_NORMAL;
          state_d = ST_OUT;
        end else begin
          state_d = ST_DETECT;
        end
      end
      // overuse rules and adaptation setup
      ST_DETECT: begin
        if (sc33 > th33) begin
          if (!armed_q) begin
            armed_d = 1'b1;
          end else if (ou_sum > 34'sh0_7FFF_FFFF) begin
            nt = 32'sh7FFF_FFFF;
          end else if (ou_sum < -34'sh0_8000_0000) begin
            nt = -32'sh8000_0000;
          end else begin
            nt = 32'(ou_sum);
          end
          ou_time_d = nt;
          hits_d    = nh;
          if (nt > $signed(32'(OVERUSE_TIME_US)) && nh > 8'd1 && trend_q > last_trend_q) begin
            ou_time_d = '0;
            hits_d    = '0;
            usage_d   = USAGE_OVER;
          end
        end else begin
          armed_d   = 1'b0;
          ou_time_d = '0;
          hits_d    = '0;
          usage_d   = (sc33 < -th33) ? USAGE_UNDER : USAGE_NORMAL;
        end
        last_trend_d = trend_q;
        adseen_d     = 1'b1;
        last_ad_d    = now_q;
        k_d    = ({1'b0, smag} < 33'(th_q)) ? cfg_i.adapt_rate_down : cfg_i.adapt_rate_up;
        diff_d = $signed({2'b0, smag}) - $signed({20'd0, th_q});
        if (now_q < la) dt_d = '0;
        else if (dtw > 49'(MAX_ADAPT_MS)) dt_d = 7'(MAX_ADAPT_MS);
        else dt_d = dtw[6:0];
        state_d = (sc33 > th33 + $signed(33'(MAX_ADAPT_OFFSET))) ? ST_OUT : ST_ADAPT1;
      end
      ST_ADAPT1: begin
        kd_d    = 51'($signed({1'b0, k_q}) * diff_q);
        state_d = ST_ADAPT2;
      end
      ST_ADAPT2: begin
        if (thn < $signed(59'(TH_MIN))) th_d = 14'(TH_MIN);
        else if (thn > $signed(59'(TH_MAX))) th_d = 14'(TH_MAX);
        else th_d = thn[13:0];
        state_d = ST_OUT;
      end
      // hand the result to the output register
      ST_OUT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d  = 1'b1;
          ousage_d  = usage_q;
          oscaled_d = scaled_q;
          oth_d     = th_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/delay_trendline_overuse_detector.sv */
// Delay trendline overuse detector. Each accepted packet-group transaction
// with a valid delta updates the accumulated and smoothed delay, stores it
// in a WINDOW-deep window and, once the window is full, fits a least-squares
// slope; the trend is then scaled by sample count and gain and classified
// against an adaptive threshold. One result transaction follows every input
// transaction. The block takes one transaction at a time: a full-window
// item sweeps the window over the single read port, then forms the two
// serial products and the quotient, all on one shared 128-bit adder.
// Registers sit on an APB port at byte address 4*index; writes are allowed
// only while the block is idle. The user must keep to this; the block itself
// does not enforce it.
`default_nettype none
module delay_trendline_overuse_detector
  import dtod_pkg::*;
#(
  parameter int unsigned WINDOW    = WINDOW_DEF,
  parameter int unsigned COUNT_CAP = COUNT_CAP_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  dtod_in_if.sink          in_i,
  dtod_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  cfg_t          cfg;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [79:0]   mem_wdata, mem_rdata;

  // configuration registers
  dtod_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // window of relative arrival and smoothed delay
  dtod_window_mem #(.DEPTH(WINDOW), .AW(IW), .DW(80)) u_mem (
    .clk_i,
    .wr_en_i(mem_we), .wr_addr_i(mem_waddr), .wr_data_i(mem_wdata),
    .rd_addr_i(mem_raddr), .rd_data_o(mem_rdata)
  );

  // sequencer and shared arithmetic
  dtod_core #(.WINDOW(WINDOW), .COUNT_CAP(COUNT_CAP)) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_i, .out_o,
    .mem_we_o(mem_we), .mem_waddr_o(mem_waddr), .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr), .mem_rdata_i(mem_rdata)
  );

endmodule
`default_nettype wire
